/* rtl/avt_pkg.sv */
`timescale 1ns / 1ps
package avt_pkg;

  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RANGE       = 2'd1,
    ST_INVALID     = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  localparam logic [KIND_W-1:0] KIND_IDENTITY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BOOL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INV_BOOL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SCALE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BITMASK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLAMP    = 3'd5;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KIND       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 3'd6;

  // request classification handed from front to back
  typedef struct packed {
    logic    fixed;   // result already known, back only carries it
    logic    enc;
    logic    pneg;    // product sign
    logic    dneg;    // divider sign
    logic    dm1;     // divider is minus one
    status_t status;
  } front_ctl_t;

endpackage

/* rtl/avt_if.sv */
`timescale 1ns / 1ps
interface avt_in_if #(parameter int W = 64);
  logic         valid;
  logic         ready;
  logic         operation;
  logic [W-1:0] value_in;
  modport source(output valid, operation, value_in, input ready);
  modport sink(input valid, operation, value_in, output ready);
endinterface

interface avt_out_if import avt_pkg::*; #(parameter int W = 64);
  logic         valid;
  logic         ready;
  status_t      status;
  logic [W-1:0] value_out;
  modport source(output valid, status, value_out, input ready);
  modport sink(input valid, status, value_out, output ready);
endinterface

interface avt_cfg_if import avt_pkg::*; #(parameter int W = 64);
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [W-1:0]         data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/avt_front.sv */
`timescale 1ns / 1ps
module avt_front import avt_pkg::*; #(
  parameter int W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [W-1:0]      in_value,
  input  logic [KIND_W-1:0] kind,
  input  logic [W-1:0]      mul,
  input  logic [W-1:0]      dvs,
  input  logic [W-1:0]      off,
  input  logic [W-1:0]      mask,
  input  logic [W-1:0]      clo,
  input  logic [W-1:0]      chi,
  output logic              fr_valid,
  input  logic              fr_ready,
  output front_ctl_t        fr_ctl,
  output logic [W-1:0]      fr_res,
  output logic [W-1:0]      fr_mag_a,
  output logic [W-1:0]      fr_mag_b,
  output logic [W-1:0]      fr_dmag,
  output logic [W-1:0]      fr_off
);

  logic         enc;
  logic [W:0]   diff;
  logic         dovf;
  logic [W-1:0] a, b, d;
  logic [W-1:0] res_c;
  status_t      st_c;
  logic         fixed_c;
  logic         vld_r, vld_nxt;
  front_ctl_t   ctl_r;
  logic [W-1:0] res_r, mag_a_r, mag_b_r, dmag_r, off_r;

  assign enc  = (in_operation == OP_ENCODE);
  assign diff = {in_value[W-1], in_value} - {off[W-1], off};
  assign dovf = diff[W] ^ diff[W-1];
  assign a    = enc ? diff[W-1:0] : in_value;
  assign b    = enc ? dvs : mul;
  assign d    = enc ? mul : dvs;

  always_comb begin
    res_c   = '0;
    st_c    = ST_OK;
    fixed_c = 1'b1;
    unique case (kind)
      KIND_IDENTITY: res_c = in_value;
      KIND_BOOL:     res_c = W'(in_value != '0);
      KIND_INV_BOOL: res_c = W'(in_value == '0);
      KIND_SCALE: begin
        if (enc) begin
          if (mul == '0 || dovf) st_c = ST_RANGE;
        end else begin
          if (dvs == '0) st_c = ST_RANGE;
        end
        fixed_c = (st_c != ST_OK);
      end
      KIND_BITMASK: begin
        if (enc) res_c = (in_value != '0) ? mask : '0;
        else     res_c = W'((in_value & mask) != '0);
      end
      KIND_CLAMP: begin
        if (enc) begin
          if ($signed(in_value) < $signed(clo) || $signed(in_value) > $signed(chi))
            st_c = ST_RANGE;
          else
            res_c = in_value;
        end else if ($signed(clo) > $signed(chi)) begin
          st_c = ST_INVALID;
        end else if ($signed(in_value) < $signed(clo)) begin
          res_c = clo;
        end else if ($signed(in_value) > $signed(chi)) begin
          res_c = chi;
        end else begin
          res_c = in_value;
        end
      end
      default: st_c = ST_UNSUPPORTED;
    endcase
    if (st_c != ST_OK) res_c = '0;
  end

  assign in_ready = !vld_r || fr_ready;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctl_r.fixed  <= fixed_c;
      ctl_r.enc    <= enc;
      ctl_r.pneg   <= a[W-1] ^ b[W-1];
      ctl_r.dneg   <= d[W-1];
      ctl_r.dm1    <= (d == '1);
      ctl_r.status <= st_c;
      res_r        <= res_c;
      mag_a_r      <= a[W-1] ? -a : a;
      mag_b_r      <= b[W-1] ? -b : b;
      dmag_r       <= d[W-1] ? -d : d;
      off_r        <= off;
    end
  end

  assign fr_valid = vld_r;
  assign fr_ctl   = ctl_r;
  assign fr_res   = res_r;
  assign fr_mag_a = mag_a_r;
  assign fr_mag_b = mag_b_r;
  assign fr_dmag  = dmag_r;
  assign fr_off   = off_r;

endmodule

/* rtl/avt_queue.sv */
`timescale 1ns / 1ps
module avt_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_data;
  end

endmodule

/* rtl/avt_back.sv */
`timescale 1ns / 1ps
module avt_back import avt_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         bk_valid,
  output logic         bk_ready,
  input  front_ctl_t   bk_ctl,
  input  logic [W-1:0] bk_res,
  input  logic [W-1:0] bk_mag_a,
  input  logic [W-1:0] bk_mag_b,
  input  logic [W-1:0] bk_dmag,
  input  logic [W-1:0] bk_off,
  output logic         out_valid,
  input  logic         out_ready,
  output status_t      out_status,
  output logic [W-1:0] out_data
);

  localparam int H = (W + 1) / 2;

  typedef struct packed {
    logic         fixed;
    logic         enc;
    logic         pneg;
    logic         dm1;
    logic         qneg;
    status_t      st;
    logic [W-1:0] res;
    logic [W-1:0] off;
    logic [W-1:0] dmag;
  } bctl_t;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign bk_ready = adv;

  // partial products of half-width magnitudes
  logic [2*H-1:0] ax, bx;
  logic           s1_vld_r;
  bctl_t          s1_c_r;
  logic [2*H-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;

  assign ax = (2*H)'(bk_mag_a);
  assign bx = (2*H)'(bk_mag_b);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= bk_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_c_r.fixed <= bk_ctl.fixed;
      s1_c_r.enc   <= bk_ctl.enc;
      s1_c_r.pneg  <= bk_ctl.pneg;
      s1_c_r.dm1   <= bk_ctl.dm1;
      s1_c_r.qneg  <= bk_ctl.pneg ^ bk_ctl.dneg;
      s1_c_r.st    <= bk_ctl.status;
      s1_c_r.res   <= bk_res;
      s1_c_r.off   <= bk_off;
      s1_c_r.dmag  <= bk_dmag;
      pp_ll_r      <= ax[H-1:0] * bx[H-1:0];
      pp_lh_r      <= ax[H-1:0] * bx[2*H-1:H];
      pp_hl_r      <= ax[2*H-1:H] * bx[H-1:0];
      pp_hh_r      <= ax[2*H-1:H] * bx[2*H-1:H];
    end
  end

  // sum partial products
  logic           s2_vld_r;
  bctl_t          s2_c_r;
  logic [4*H-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_c_r <= s1_c_r;
      prod_r <= (4*H)'(pp_ll_r) + ((4*H)'(pp_lh_r) << H) + ((4*H)'(pp_hl_r) << H)
              + ((4*H)'(pp_hh_r) << (2*H));
    end
  end

  // range check of the signed product
  logic         up_nz, lo_nz, povf, mindiv;
  bctl_t        s3_c_nxt;
  logic         s3_vld_r;
  bctl_t        s3_c_r;
  logic [W-1:0] s3_dd_r;

  assign up_nz  = |prod_r[4*H-1:W];
  assign lo_nz  = |prod_r[W-2:0];
  assign povf   = up_nz || (prod_r[W-1] && (!s2_c_r.pneg || lo_nz));
  assign mindiv = !up_nz && prod_r[W-1] && !lo_nz && s2_c_r.pneg && s2_c_r.dm1;

  always_comb begin
    s3_c_nxt = s2_c_r;
    if (!s2_c_r.fixed && (povf || mindiv)) begin
      s3_c_nxt.fixed = 1'b1;
      s3_c_nxt.st    = ST_RANGE;
      s3_c_nxt.res   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_c_r  <= s3_c_nxt;
      s3_dd_r <= prod_r[W-1:0];
    end
  end

  // restoring divider, one quotient bit per stage
  logic         dv_vld_r [W];
  bctl_t        dv_c_r   [W];
  logic [W-1:0] rem_r    [W];
  logic [W-1:0] dq_r     [W];

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_div
      logic         vi;
      bctl_t        ci;
      logic [W-1:0] ri, qi;
      logic [W:0]   rsh, rsub;

      if (k == 0) begin : g_first
        assign vi = s3_vld_r;
        assign ci = s3_c_r;
        assign ri = '0;
        assign qi = s3_dd_r;
      end else begin : g_next
        assign vi = dv_vld_r[k-1];
        assign ci = dv_c_r[k-1];
        assign ri = rem_r[k-1];
        assign qi = dq_r[k-1];
      end

      assign rsh  = {ri, qi[W-1]};
      assign rsub = rsh - {1'b0, ci.dmag};

      always_ff @(posedge clk) begin
        if (!rst_n) dv_vld_r[k] <= 1'b0;
        else if (adv) dv_vld_r[k] <= vi;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_c_r[k] <= ci;
          if (!rsub[W]) begin
            rem_r[k] <= rsub[W-1:0];
            dq_r[k]  <= {qi[W-2:0], 1'b1};
          end else begin
            rem_r[k] <= rsh[W-1:0];
            dq_r[k]  <= {qi[W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // sign the quotient, add offset on decode
  bctl_t        fc;
  logic [W-1:0] q;
  logic [W:0]   sum;
  status_t      st_nxt;
  logic [W-1:0] val_nxt;
  logic         vld_r;
  status_t      st_r;
  logic [W-1:0] val_r;

  assign fc  = dv_c_r[W-1];
  assign q   = fc.qneg ? -dq_r[W-1] : dq_r[W-1];
  assign sum = {q[W-1], q} + {fc.off[W-1], fc.off};

  always_comb begin
    if (fc.fixed) begin
      st_nxt  = fc.st;
      val_nxt = fc.res;
    end else if (fc.enc) begin
      st_nxt  = ST_OK;
      val_nxt = q;
    end else if (sum[W] ^ sum[W-1]) begin
      st_nxt  = ST_RANGE;
      val_nxt = '0;
    end else begin
      st_nxt  = ST_OK;
      val_nxt = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (adv) vld_r <= dv_vld_r[W-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r  <= st_nxt;
      val_r <= val_nxt;
    end
  end

  assign out_valid  = vld_r;
  assign out_status = st_r;
  assign out_data   = val_r;

endmodule

/* rtl/attribute_value_transform.sv */
`timescale 1ns / 1ps
// Attribute value transform: decode (raw to normalized) or encode (normalized
// to raw) of a signed VALUE_WIDTH-bit value under the configured kind.
// Channels: in_ch takes {operation, value_in}, out_ch gives {status,
// value_out}, both valid/ready; a request moves when valid and ready are high.
// cfg_ch writes register index/data and is always ready; write it only while
// no request is in flight.
// Pipeline: the front classify register loads at the accept, then one queue
// slot, two multiplier stages (four half-width partial products, then their
// sum), one product range check, one restoring divider stage per quotient
// bit, and the output register with offset add.
// Throughput: one request per cycle while out_ch takes results; every stage
// is its own register, so requests follow each other back to back.
// Reset: the config registers return to identity kind, multiplier and
// divisor 1, the rest 0; pipeline and queue empty.
// Stall: when a result waits and out_ch is not ready the back pipeline
// holds, the two-entry queue between front and back fills, then the front
// holds and in_ch.ready drops.
module attribute_value_transform import avt_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  avt_in_if.sink    in_ch,
  avt_out_if.source out_ch,
  avt_cfg_if.sink   cfg_ch
);

  localparam int W  = VALUE_WIDTH;
  localparam int QW = $bits(front_ctl_t) + 5 * W;

  logic [KIND_W-1:0] kind_r;
  logic [W-1:0]      mul_r, dvs_r, off_r, mask_r, clo_r, chi_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_IDENTITY;
      mul_r  <= W'(1);
      dvs_r  <= W'(1);
      off_r  <= '0;
      mask_r <= '0;
      clo_r  <= '0;
      chi_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_KIND:       kind_r <= cfg_ch.data[KIND_W-1:0];
        REG_MULTIPLIER: mul_r  <= cfg_ch.data;
        REG_DIVISOR:    dvs_r  <= cfg_ch.data;
        REG_OFFSET:     off_r  <= cfg_ch.data;
        REG_MASK:       mask_r <= cfg_ch.data;
        REG_CLAMP_LOW:  clo_r  <= cfg_ch.data;
        REG_CLAMP_HIGH: chi_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic         fr_valid, fr_ready;
  front_ctl_t   fr_ctl;
  logic [W-1:0] fr_res, fr_mag_a, fr_mag_b, fr_dmag, fr_off;

  avt_front #(.W(W)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .in_value     (in_ch.value_in),
    .kind         (kind_r),
    .mul          (mul_r),
    .dvs          (dvs_r),
    .off          (off_r),
    .mask         (mask_r),
    .clo          (clo_r),
    .chi          (chi_r),
    .fr_valid     (fr_valid),
    .fr_ready     (fr_ready),
    .fr_ctl       (fr_ctl),
    .fr_res       (fr_res),
    .fr_mag_a     (fr_mag_a),
    .fr_mag_b     (fr_mag_b),
    .fr_dmag      (fr_dmag),
    .fr_off       (fr_off)
  );

  logic          bk_valid, bk_ready;
  logic [QW-1:0] q_wr, q_rd;
  front_ctl_t    bk_ctl;
  logic [W-1:0]  bk_res, bk_mag_a, bk_mag_b, bk_dmag, bk_off;

  assign q_wr = {fr_ctl, fr_res, fr_mag_a, fr_mag_b, fr_dmag, fr_off};
  assign {bk_ctl, bk_res, bk_mag_a, bk_mag_b, bk_dmag, bk_off} = q_rd;

  avt_queue #(.DW(QW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (q_wr),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_data  (q_rd)
  );

  avt_back #(.W(W)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bk_valid   (bk_valid),
    .bk_ready   (bk_ready),
    .bk_ctl     (bk_ctl),
    .bk_res     (bk_res),
    .bk_mag_a   (bk_mag_a),
    .bk_mag_b   (bk_mag_b),
    .bk_dmag    (bk_dmag),
    .bk_off     (bk_off),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_data   (out_ch.value_out)
  );

endmodule

/* sim/attribute_value_transform_tb.sv */
`timescale 1ns / 1ps
module attribute_value_transform_tb;
  import avt_pkg::*;

  localparam int LATENCY = 69;

  localparam logic [2:0] KIND_RSVD_A = 3'd6;
  localparam logic [2:0] KIND_RSVD_B = 3'd7;
  localparam logic [2:0] REG_NONE    = 3'd7;

  class conversion_scoreboard;
    status_t       exp_status[$];
    logic [63:0]   exp_value[$];
    int            errors;
    int            checked;
    logic [2:0]    kind;
    longint        mul, dvs, ofs, msk, clo, chi;

    function new();
      errors = 0; checked = 0;
      kind = KIND_IDENTITY; mul = 1; dvs = 1; ofs = 0; msk = 0; clo = 0; chi = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        REG_KIND:       kind = d[2:0];
        REG_MULTIPLIER: mul = d;
        REG_DIVISOR:    dvs = d;
        REG_OFFSET:     ofs = d;
        REG_MASK:       msk = d;
        REG_CLAMP_LOW:  clo = d;
        REG_CLAMP_HIGH: chi = d;
        default: ;
      endcase
    endfunction

    // 128-bit arithmetic holds the exact result, so the overflow checks can see it
    function bit fits(logic signed [127:0] x);
      return x >= -(128'sd1 <<< 63) && x < (128'sd1 <<< 63);
    endfunction

    function void note_request(logic op, logic [63:0] vin);
      longint v;
      logic signed [127:0] p;
      status_t st;
      longint r;
      v = vin; st = ST_OK; r = 0;
      case (kind)
        KIND_IDENTITY: r = v;
        KIND_BOOL:     r = (v != 0);
        KIND_INV_BOOL: r = (v == 0);
        KIND_SCALE: begin
          if (op == OP_DECODE) begin
            p = 128'(v) * 128'(mul);
            if (dvs == 0 || !fits(p)) st = ST_RANGE;
            else begin
              p = p / 128'(dvs);
              if (!fits(p)) st = ST_RANGE;
              else begin
                p = p + 128'(ofs);
                if (!fits(p)) st = ST_RANGE; else r = p[63:0];
              end
            end
          end else begin
            p = 128'(v) - 128'(ofs);
            if (mul == 0 || !fits(p)) st = ST_RANGE;
            else begin
              p = p * 128'(dvs);
              if (!fits(p)) st = ST_RANGE;
              else begin
                p = p / 128'(mul);
                if (!fits(p)) st = ST_RANGE; else r = p[63:0];
              end
            end
          end
        end
        KIND_BITMASK: begin
          if (op == OP_DECODE) r = ((v & msk) != 0);
          else r = (v != 0) ? msk : 0;
        end
        KIND_CLAMP: begin
          if (op == OP_DECODE) begin
            if (clo > chi) st = ST_INVALID;
            else r = v < clo ? clo : (v > chi ? chi : v);
          end else if (v < clo || v > chi) st = ST_RANGE;
          else r = v;
        end
        default: st = ST_UNSUPPORTED;
      endcase
      if (st != ST_OK) r = 0;
      exp_status.push_back(st);
      exp_value.push_back(r);
    endfunction

    function void check_result(status_t st, logic [63:0] val);
      status_t es;
      logic [63:0] ev;
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $time, st, val);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ev = exp_value.pop_front();
      checked++;
      if (st !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        errors++;
      end
      if (val !== ev) begin
        $display("%0t: value expected %h actual %h", $time, ev, val);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  avt_in_if  #(64) in_ch();
  avt_out_if #(64) out_ch();
  avt_cfg_if #(64) cfg_ch();

  attribute_value_transform #(.VALUE_WIDTH(64)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  conversion_scoreboard sb;
  int send_idle_pct, recv_stall_pct, hold_off_cycles, sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("attribute_value_transform_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.operation, in_ch.value_in);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.status, out_ch.value_out);
  end

  // receiver: random stall, plus a long hold-off counted here
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'(longint'($urandom_range(20)) - 10);
      3: return 64'(longint'(int'($urandom())));
      4: return 64'd1 << $urandom_range(63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // valid stays high after an accept so the next request can follow at once
  task automatic send(logic op, logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.value_in <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // caller drops cfg_ch.valid after the last write of a sequence
  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic setup(logic [2:0] k, logic [63:0] m, logic [63:0] d, logic [63:0] o,
                       logic [63:0] bm, logic [63:0] lo, logic [63:0] hi);
    drain();
    write_reg(REG_KIND, k);
    write_reg(REG_MULTIPLIER, m);
    write_reg(REG_DIVISOR, d);
    write_reg(REG_OFFSET, o);
    write_reg(REG_MASK, bm);
    write_reg(REG_CLAMP_LOW, lo);
    write_reg(REG_CLAMP_HIGH, hi);
    cfg_ch.valid <= 1'b0;
  endtask

  // pick a register setting; small values dominate so scale results mostly succeed
  task automatic random_setup();
    logic [63:0] lo, hi;
    lo = rand64(); hi = rand64();
    if ($urandom_range(3) != 0 && $signed(lo) > $signed(hi)) begin
      lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
    end
    setup(3'($urandom_range(7)),
          $urandom_range(3) ? 64'(longint'($urandom_range(2000)) - 1000) : rand64(),
          $urandom_range(3) ? 64'(longint'($urandom_range(200)) - 100) : rand64(),
          $urandom_range(3) ? 64'(longint'($urandom_range(20000)) - 10000) : rand64(),
          rand64(), lo, hi);
  endtask

  localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG1 = '1;

  initial begin
    sb = new();
    rst_n = 0; sent = 0; hold_off_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    in_ch.valid = 0; in_ch.operation = 0; in_ch.value_in = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    out_ch.ready = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings (identity), then each kind and corner
    send(OP_DECODE, MINV); send(OP_ENCODE, MAXV);
    setup(KIND_BOOL, 1, 1, 0, 0, 0, 0);  send(OP_DECODE, 0); send(OP_ENCODE, MINV);
    setup(KIND_INV_BOOL, 1, 1, 0, 0, 0, 0); send(OP_DECODE, 0); send(OP_ENCODE, 5);
    // most negative over minus one
    setup(KIND_SCALE, 1, NEG1, 0, 0, 0, 0); send(OP_DECODE, MINV); send(OP_DECODE, 7);
    send(OP_ENCODE, 3);
    setup(KIND_SCALE, NEG1, 1, 0, 0, 0, 0); send(OP_ENCODE, MINV);
    // zero divisor / multiplier
    setup(KIND_SCALE, 0, 0, 0, 0, 0, 0); send(OP_DECODE, 4); send(OP_ENCODE, 4);
    setup(KIND_SCALE, 3, 0, 5, 0, 0, 0); send(OP_ENCODE, 9);
    // product and offset overflow
    setup(KIND_SCALE, 2, 3, MAXV, 0, 0, 0); send(OP_DECODE, MAXV); send(OP_DECODE, 3);
    send(OP_ENCODE, MINV);
    setup(KIND_BITMASK, 1, 1, 0, MINV, 0, 0); send(OP_DECODE, MINV); send(OP_DECODE, MAXV);
    send(OP_ENCODE, 1); send(OP_ENCODE, 0);
    setup(KIND_CLAMP, 1, 1, 0, 0, MINV, MAXV); send(OP_DECODE, MAXV); send(OP_ENCODE, MINV);
    setup(KIND_CLAMP, 1, 1, 0, 0, 10, -64'sd10); send(OP_DECODE, 0); send(OP_ENCODE, 0);
    setup(KIND_RSVD_A, 1, 1, 0, 0, 0, 0); send(OP_DECODE, 1);
    setup(KIND_RSVD_B, 1, 1, 0, 0, 0, 0); send(OP_ENCODE, 1);
    drain();
    write_reg(REG_NONE, MAXV);  // out-of-range index, ignored
    cfg_ch.valid <= 1'b0;

    // random phases over idling patterns
    for (int ph = 0; ph < 12; ph++) begin
      random_setup();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (ph == 4) begin
        send_idle_pct = 0;
        hold_off_cycles = 200;  // block fills and stalls its input
      end
      for (int i = 0; i < ((ph == 4) ? 100 : 32); i++) send($urandom_range(1), rand64());
    end

    drain();
    $display("covered %0d requests, %0d results checked, all kinds and both directions",
             sent, sb.checked);
    if (sb.errors == 0 && sb.exp_status.size() == 0)
      $display("attribute_value_transform_tb: clean");
    else
      $display("attribute_value_transform_tb: errors");
    $finish;
  end
endmodule
